### hdl/pcap_syn_pkg.sv
// Package for the pcap TCP SYN counter: phase and status codes, header
// constants and the saturating increment. No dependencies.
`default_nettype none

package pcap_syn_pkg;

    localparam int unsigned ADDR_W = 3;
    localparam int unsigned DATA_W = 32;

    // register index taken from paddr[2]
    localparam logic REG_SERVER_PORT = 1'b0;

    localparam logic [15:0] SERVER_PORT_RESET = 16'd80;

    localparam logic [31:0] PCAP_MAGIC   = 32'hA1B2_C3D4;
    localparam logic [7:0]  FLAGS_SYN    = 8'h02;
    localparam logic [7:0]  FLAGS_SYNACK = 8'h12;
    localparam logic [7:0]  IHL_MASK     = 8'h0F;

    localparam logic [4:0] GLOBAL_LAST   = 5'd23;
    localparam logic [4:0] LINK_FIRST    = 5'd20;
    localparam logic [3:0] RECHDR_LAST   = 4'd15;
    localparam logic [3:0] CAPLEN_FIRST  = 4'd8;
    localparam logic [3:0] CAPLEN_LAST   = 4'd11;
    localparam logic [2:0] IHL_OFFSET    = 3'd4;
    localparam logic [3:0] IHL_MIN       = 4'd5;
    localparam logic [5:0] IP_MIN_BYTES  = 6'd20;
    localparam logic [6:0] LOOPBACK_LEN  = 7'd4;
    localparam logic [4:0] TCP_IP_START  = 5'd24;
    localparam logic [6:0] TCP_FLAGS_OFS = 7'd13;

    typedef enum logic [1:0] {
        PH_GLOBAL = 2'd0,
        PH_RECHDR = 2'd1,
        PH_BODY   = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_LINK  = 2'd1,
        ST_MAGIC = 2'd2
    } status_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

`default_nettype wire

### hdl/pcap_tcp_syn_counter.sv
// Top level of the pcap TCP SYN and SYN/ACK counter: byte parser, counters,
// result register and APB register port. Depends on pcap_syn_pkg.
`default_nettype none

// Takes a little-endian pcap capture of loopback IPv4/TCP traffic one byte per
// clock while in_ready is high and returns one transaction per completed record
// with saturating totals of records, SYNs to server_port and SYN/ACKs from
// server_port. The parser state and the counters update at the edge that
// accepts the byte, and the result lands in an output register, so in_ready
// stays high whenever that register is empty or being drained. A bad global
// header yields one transaction with status 1 (link type not 0) or 2 (bad
// magic) and the block then drops all bytes until reset. server_port lives at
// address 0 (reset 80).
module pcap_tcp_syn_counter (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [7:0]                         data_byte,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [1:0]                              status,
    output logic [31:0]                             packet_count,
    output logic [31:0]                             syn_count,
    output logic [31:0]                             synack_count,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [pcap_syn_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [pcap_syn_pkg::DATA_W-1:0]    pwdata,
    output logic [pcap_syn_pkg::DATA_W-1:0]         prdata,
    output logic                                    pready
);

    pcap_syn_pkg::phase_t phase_reg, phase_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] reclen_reg, reclen_next;
    logic [31:0] magic_reg, magic_next;
    logic [3:0]  ihl_reg, ihl_next;
    logic [15:0] src_port_reg, src_port_next;
    logic [15:0] dst_port_reg, dst_port_next;
    logic [31:0] pkt_total_reg, pkt_total_next;
    logic [31:0] syn_total_reg, syn_total_next;
    logic [31:0] synack_total_reg, synack_total_next;
    logic [15:0] server_port_reg;

    logic                   out_valid_reg;
    pcap_syn_pkg::status_t  status_reg;
    logic [31:0]            packet_count_reg, syn_count_reg, synack_count_reg;

    logic                   in_fire;
    logic                   emit;
    pcap_syn_pkg::status_t  emit_status;
    logic [5:0]             ip_len;
    logic [6:0]             tcp_ofs;
    logic                   off_small;
    logic [6:0]             off_low;
    logic [7:0]             ihl_byte;

    // ---------------- APB register port
    assign pready = 1'b1;

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == pcap_syn_pkg::REG_SERVER_PORT)
        begin
            prdata = {16'd0, server_port_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_port_reg <= pcap_syn_pkg::SERVER_PORT_RESET;
        end
        else if (psel && penable && pwrite && pready
                 && paddr[2] == pcap_syn_pkg::REG_SERVER_PORT)
        begin
            server_port_reg <= pwdata[15:0];
        end
    end

    // ---------------- byte parser
    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign ip_len    = (ihl_reg < pcap_syn_pkg::IHL_MIN) ? pcap_syn_pkg::IP_MIN_BYTES
                                                          : {ihl_reg, 2'b00};
    assign tcp_ofs   = pcap_syn_pkg::LOOPBACK_LEN + {1'b0, ip_len};
    assign off_small = (offset_reg[31:7] == 25'd0);
    assign off_low   = offset_reg[6:0];
    assign ihl_byte  = data_byte & pcap_syn_pkg::IHL_MASK;

    always_comb
    begin
        phase_next        = phase_reg;
        offset_next       = offset_reg;
        reclen_next       = reclen_reg;
        magic_next        = magic_reg;
        ihl_next          = ihl_reg;
        src_port_next     = src_port_reg;
        dst_port_next     = dst_port_reg;
        pkt_total_next    = pkt_total_reg;
        syn_total_next    = syn_total_reg;
        synack_total_next = synack_total_reg;
        emit              = 1'b0;
        emit_status       = pcap_syn_pkg::ST_DONE;

        unique case (phase_reg)
            pcap_syn_pkg::PH_GLOBAL:
            begin
                if (offset_reg[4:0] < 5'd4)
                begin
                    case (offset_reg[1:0])
                        2'd0:    magic_next[7:0]   = magic_reg[7:0]   | data_byte;
                        2'd1:    magic_next[15:8]  = magic_reg[15:8]  | data_byte;
                        2'd2:    magic_next[23:16] = magic_reg[23:16] | data_byte;
                        default: magic_next[31:24] = magic_reg[31:24] | data_byte;
                    endcase
                end
                else if (offset_reg[4:0] >= pcap_syn_pkg::LINK_FIRST)
                begin
                    // fold the link type bytes together, only zero is accepted
                    reclen_next = reclen_reg | {24'd0, data_byte};
                end
                if (offset_reg[4:0] < pcap_syn_pkg::GLOBAL_LAST)
                begin
                    offset_next = offset_reg + 32'd1;
                end
                else if (reclen_next != 32'd0)
                begin
                    phase_next  = pcap_syn_pkg::PH_HALT;
                    emit        = 1'b1;
                    emit_status = pcap_syn_pkg::ST_LINK;
                end
                else if (magic_next != pcap_syn_pkg::PCAP_MAGIC)
                begin
                    phase_next  = pcap_syn_pkg::PH_HALT;
                    emit        = 1'b1;
                    emit_status = pcap_syn_pkg::ST_MAGIC;
                end
                else
                begin
                    phase_next  = pcap_syn_pkg::PH_RECHDR;
                    offset_next = '0;
                    reclen_next = '0;
                end
            end

            pcap_syn_pkg::PH_RECHDR:
            begin
                if (offset_reg[3:0] == 4'd0)
                begin
                    reclen_next   = '0;
                    ihl_next      = '0;
                    src_port_next = '0;
                    dst_port_next = '0;
                end
                if (offset_reg[3:0] >= pcap_syn_pkg::CAPLEN_FIRST
                    && offset_reg[3:0] <= pcap_syn_pkg::CAPLEN_LAST)
                begin
                    case (offset_reg[1:0])
                        2'd0:    reclen_next[7:0]   = reclen_reg[7:0]   | data_byte;
                        2'd1:    reclen_next[15:8]  = reclen_reg[15:8]  | data_byte;
                        2'd2:    reclen_next[23:16] = reclen_reg[23:16] | data_byte;
                        default: reclen_next[31:24] = reclen_reg[31:24] | data_byte;
                    endcase
                end
                if (offset_reg[3:0] < pcap_syn_pkg::RECHDR_LAST)
                begin
                    offset_next = offset_reg + 32'd1;
                end
                else if (reclen_next == 32'd0)
                begin
                    // empty record ends on its last header byte
                    pkt_total_next = pcap_syn_pkg::sat_inc(pkt_total_reg);
                    phase_next     = pcap_syn_pkg::PH_RECHDR;
                    offset_next    = '0;
                    emit           = 1'b1;
                end
                else
                begin
                    phase_next  = pcap_syn_pkg::PH_BODY;
                    offset_next = '0;
                end
            end

            pcap_syn_pkg::PH_BODY:
            begin
                if (offset_reg == {29'd0, pcap_syn_pkg::IHL_OFFSET})
                begin
                    ihl_next = ihl_byte[3:0];
                end
                else if (off_small && off_low >= {2'b00, pcap_syn_pkg::TCP_IP_START})
                begin
                    if (off_low == tcp_ofs)
                    begin
                        src_port_next = {data_byte, 8'd0};
                    end
                    else if (off_low == tcp_ofs + 7'd1)
                    begin
                        src_port_next = src_port_reg | {8'd0, data_byte};
                    end
                    else if (off_low == tcp_ofs + 7'd2)
                    begin
                        dst_port_next = {data_byte, 8'd0};
                    end
                    else if (off_low == tcp_ofs + 7'd3)
                    begin
                        dst_port_next = dst_port_reg | {8'd0, data_byte};
                    end
                    else if (off_low == tcp_ofs + pcap_syn_pkg::TCP_FLAGS_OFS)
                    begin
                        if (dst_port_reg == server_port_reg
                            && data_byte == pcap_syn_pkg::FLAGS_SYN)
                        begin
                            syn_total_next = pcap_syn_pkg::sat_inc(syn_total_reg);
                        end
                        if (src_port_reg == server_port_reg
                            && data_byte == pcap_syn_pkg::FLAGS_SYNACK)
                        begin
                            synack_total_next = pcap_syn_pkg::sat_inc(synack_total_reg);
                        end
                    end
                end
                if (offset_reg + 32'd1 >= reclen_reg)
                begin
                    pkt_total_next = pcap_syn_pkg::sat_inc(pkt_total_reg);
                    phase_next     = pcap_syn_pkg::PH_RECHDR;
                    offset_next    = '0;
                    emit           = 1'b1;
                end
                else
                begin
                    offset_next = offset_reg + 32'd1;
                end
            end

            pcap_syn_pkg::PH_HALT:
            begin
                // drop everything until reset
            end

            default:
            begin
                phase_next = pcap_syn_pkg::PH_HALT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= pcap_syn_pkg::PH_GLOBAL;
            offset_reg       <= '0;
            reclen_reg       <= '0;
            magic_reg        <= '0;
            ihl_reg          <= '0;
            src_port_reg     <= '0;
            dst_port_reg     <= '0;
            pkt_total_reg    <= '0;
            syn_total_reg    <= '0;
            synack_total_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg        <= phase_next;
            offset_reg       <= offset_next;
            reclen_reg       <= reclen_next;
            magic_reg        <= magic_next;
            ihl_reg          <= ihl_next;
            src_port_reg     <= src_port_next;
            dst_port_reg     <= dst_port_next;
            pkt_total_reg    <= pkt_total_next;
            syn_total_reg    <= syn_total_next;
            synack_total_reg <= synack_total_next;
        end
    end

    // ---------------- result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && emit)
        begin
            status_reg       <= emit_status;
            packet_count_reg <= pkt_total_next;
            syn_count_reg    <= syn_total_next;
            synack_count_reg <= synack_total_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign packet_count = packet_count_reg;
    assign syn_count    = syn_count_reg;
    assign synack_count = synack_count_reg;

`ifndef SYNTHESIS
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == pcap_syn_pkg::PH_HALT |=> phase_reg == pcap_syn_pkg::PH_HALT)
        else $error("parser left halt state");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg != pcap_syn_pkg::ST_DONE
        |-> phase_reg == pcap_syn_pkg::PH_HALT)
        else $error("error transaction without halt");

    a_pkt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> pkt_total_reg >= $past(pkt_total_reg))
        else $error("packet total decreased");

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == pcap_syn_pkg::PH_HALT && in_fire
        |=> $stable(pkt_total_reg) && $stable(syn_total_reg) && $stable(synack_total_reg))
        else $error("totals changed after halt");
`endif

endmodule

`default_nettype wire

### dv/pcap_tcp_syn_counter_test.sv
// Testbench for pcap_tcp_syn_counter: streams pcap captures one byte per transaction,
// predicts each record result with its own parser and checks every field of it.
// Depends on pcap_syn_pkg and the pcap_tcp_syn_counter RTL.
`default_nettype none

module pcap_tcp_syn_counter_test;

    localparam int unsigned IDLE_PCT       = 21;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned PHASE_BYTES    = 130;
    localparam logic [pcap_syn_pkg::ADDR_W-1:0] PORT_ADDR =
        {pcap_syn_pkg::REG_SERVER_PORT, 2'b00};

    typedef struct packed {
        pcap_syn_pkg::status_t st;
        logic [31:0]           pkts;
        logic [31:0]           syns;
        logic [31:0]           synacks;
    } tally_t;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              in_valid  = 1'b0;
    logic                              in_ready;
    logic [7:0]                        data_byte = 8'h00;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [1:0]                        status;
    logic [31:0]                       packet_count;
    logic [31:0]                       syn_count;
    logic [31:0]                       synack_count;
    logic                              psel      = 1'b0;
    logic                              penable   = 1'b0;
    logic                              pwrite    = 1'b0;
    logic [pcap_syn_pkg::ADDR_W-1:0]   paddr     = '0;
    logic [pcap_syn_pkg::DATA_W-1:0]   pwdata    = '0;
    logic [pcap_syn_pkg::DATA_W-1:0]   prdata;
    logic                              pready;

    logic [7:0]  pending_bytes[$];
    tally_t      tally_q[$];
    int unsigned bytes_taken  = 0;
    int unsigned results_seen = 0;
    int unsigned fail_count   = 0;
    int unsigned idle_cycles  = 0;
    int unsigned hold_left    = 0;
    bit          hold_done    = 1'b0;
    bit          in_taken     = 1'b0;
    logic        no_idle;

    // parser state, starts at its reset values
    pcap_syn_pkg::phase_t parse_phase = pcap_syn_pkg::PH_GLOBAL;
    logic [31:0] parse_pos   = '0;
    logic [31:0] cap_len     = '0;
    logic [31:0] magic_acc   = '0;
    logic [3:0]  ihl_seen    = '0;
    logic [15:0] sport_seen  = '0;
    logic [15:0] dport_seen  = '0;
    logic [31:0] pkts_tot    = '0;
    logic [31:0] syn_tot     = '0;
    logic [31:0] synack_tot  = '0;
    logic [15:0] port_cfg    = pcap_syn_pkg::SERVER_PORT_RESET;

    assign no_idle = (bytes_taken >= 900) && (bytes_taken < 1500);

    pcap_tcp_syn_counter dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .packet_count (packet_count),
        .syn_count    (syn_count),
        .synack_count (synack_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // byte offset of the TCP header inside a record body
    function automatic int unsigned tcp_offset(input logic [3:0] ihl);
        return 4 + ((ihl < 4'd5) ? 20 : 4 * int'(ihl));
    endfunction

    function automatic tally_t snapshot(input pcap_syn_pkg::status_t st);
        tally_t t;
        t.st      = st;
        t.pkts    = pkts_tot;
        t.syns    = syn_tot;
        t.synacks = synack_tot;
        return t;
    endfunction

    function automatic tally_t close_record();
        pkts_tot    = bump(pkts_tot);
        parse_phase = pcap_syn_pkg::PH_RECHDR;
        parse_pos   = '0;
        return snapshot(pcap_syn_pkg::ST_DONE);
    endfunction

    // advance the parser by one byte; returns 1 when the byte ends a record or a bad global header
    function automatic bit parse_byte(input logic [7:0] b, output tally_t res);
        logic [31:0] pos;
        logic [31:0] tcp_at;
        pos = parse_pos;
        res = snapshot(pcap_syn_pkg::ST_DONE);
        parse_byte = 1'b0;
        case (parse_phase)
            pcap_syn_pkg::PH_GLOBAL:
            begin
                if (pos < 4)
                    magic_acc |= 32'(b) << (8 * pos);
                else if (pos >= 20)
                    cap_len |= 32'(b);
                if (pos < 23)
                    parse_pos = pos + 1;
                else if (cap_len != 0)
                begin
                    parse_phase = pcap_syn_pkg::PH_HALT;
                    res = snapshot(pcap_syn_pkg::ST_LINK);
                    parse_byte = 1'b1;
                end
                else if (magic_acc != pcap_syn_pkg::PCAP_MAGIC)
                begin
                    parse_phase = pcap_syn_pkg::PH_HALT;
                    res = snapshot(pcap_syn_pkg::ST_MAGIC);
                    parse_byte = 1'b1;
                end
                else
                begin
                    parse_phase = pcap_syn_pkg::PH_RECHDR;
                    parse_pos = '0;
                    cap_len = '0;
                end
            end
            pcap_syn_pkg::PH_RECHDR:
            begin
                if (pos == 0)
                begin
                    cap_len    = '0;
                    ihl_seen   = '0;
                    sport_seen = '0;
                    dport_seen = '0;
                end
                if (pos >= 8 && pos < 12)
                    cap_len |= 32'(b) << (8 * (pos - 8));
                if (pos < 15)
                    parse_pos = pos + 1;
                else if (cap_len == 0)
                begin
                    res = close_record();
                    parse_byte = 1'b1;
                end
                else
                begin
                    parse_phase = pcap_syn_pkg::PH_BODY;
                    parse_pos = '0;
                end
            end
            pcap_syn_pkg::PH_BODY:
            begin
                tcp_at = tcp_offset(ihl_seen);
                if (pos == 4)
                    ihl_seen = b[3:0];
                else if (pos >= 24)
                begin
                    if (pos == tcp_at)
                        sport_seen = {b, 8'h00};
                    else if (pos == tcp_at + 1)
                        sport_seen = sport_seen | 16'(b);
                    else if (pos == tcp_at + 2)
                        dport_seen = {b, 8'h00};
                    else if (pos == tcp_at + 3)
                        dport_seen = dport_seen | 16'(b);
                    else if (pos == tcp_at + 13)
                    begin
                        if (dport_seen == port_cfg && b == pcap_syn_pkg::FLAGS_SYN)
                            syn_tot = bump(syn_tot);
                        if (sport_seen == port_cfg && b == pcap_syn_pkg::FLAGS_SYNACK)
                            synack_tot = bump(synack_tot);
                    end
                end
                if (pos + 1 >= cap_len)
                begin
                    res = close_record();
                    parse_byte = 1'b1;
                end
                else
                    parse_pos = pos + 1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // record header with the given captured length, then the loopback/IPv4/TCP body
    function automatic void queue_record(input logic [31:0] len, input logic [7:0] ver_ihl,
                                         input logic [15:0] sport, input logic [15:0] dport,
                                         input logic [7:0] flags);
        int unsigned tcp_at;
        logic [7:0]  b;
        tcp_at = tcp_offset(ver_ihl[3:0]);
        for (int i = 0; i < 16; i++)
            pending_bytes.push_back((i >= 8 && i < 12) ? 8'(len >> (8 * (i - 8)))
                                                        : 8'($urandom));
        for (int unsigned k = 0; k < len; k++)
        begin
            if (k == 4)
                b = ver_ihl;
            else if (k == tcp_at)
                b = sport[15:8];
            else if (k == tcp_at + 1)
                b = sport[7:0];
            else if (k == tcp_at + 2)
                b = dport[15:8];
            else if (k == tcp_at + 3)
                b = dport[7:0];
            else if (k == tcp_at + 13)
                b = flags;
            else
                b = 8'($urandom);
            pending_bytes.push_back(b);
        end
    endfunction

    function automatic logic [15:0] pick_port();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 45)
            return port_cfg;
        if (roll < 55)
            return port_cfg ^ 16'h0001;
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] pick_flags();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 35)
            return pcap_syn_pkg::FLAGS_SYN;
        if (roll < 70)
            return pcap_syn_pkg::FLAGS_SYNACK;
        return 8'($urandom);
    endfunction

    // mostly full TCP records, some empty, truncated or long ones; returns bytes queued
    function automatic int unsigned queue_random_record();
        logic [7:0]  ver_ihl;
        int unsigned tcp_at;
        int unsigned len;
        int unsigned roll;
        ver_ihl = ($urandom_range(99) < 60) ? 8'h45 : 8'($urandom);
        tcp_at = tcp_offset(ver_ihl[3:0]);
        roll = $urandom_range(99);
        if (roll < 6)
            len = 0;
        else if (roll < 16)
            len = $urandom_range(tcp_at + 13, 1);
        else if (roll < 19)
            len = $urandom_range(320, 256);
        else
            len = tcp_at + 14 + $urandom_range(24);
        queue_record(len, ver_ihl, pick_port(), pick_port(), pick_flags());
        return 16 + len;
    endfunction

    task automatic log_mismatch(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("MISMATCH: %s", what);
    endtask

    task automatic write_server_port(input logic [15:0] port);
        logic [pcap_syn_pkg::DATA_W-1:0] readback;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PORT_ADDR;
        pwdata  <= pcap_syn_pkg::DATA_W'(port);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        readback = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        port_cfg = port;
        if (readback !== pcap_syn_pkg::DATA_W'(port))
            log_mismatch($sformatf("server_port readback: expected %0d, got %0d",
                                   port, readback));
    endtask

    // wait for every queued byte to go in and every expected result to come out
    task automatic settle();
        while (pending_bytes.size() > 0 || in_valid || tally_q.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // sender
    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_bytes.size() > 0 && (no_idle || $urandom_range(99) >= IDLE_PCT))
            begin
                in_valid  <= 1'b1;
                data_byte <= pending_bytes.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
        in_taken = 1'b0;
    end

    // receiver
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (!hold_done && results_seen >= 10 && pending_bytes.size() > 200)
        begin
            // hold off long enough for the result register to back up the input
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
            out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    // check results, then predict from the byte taken at this edge
    always @(posedge clk)
    begin
        tally_t want;
        tally_t got;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (tally_q.size() == 0)
                    log_mismatch($sformatf("unexpected result: status %0d counts %0d/%0d/%0d",
                                           status, packet_count, syn_count, synack_count));
                else
                begin
                    want = tally_q.pop_front();
                    if (status !== want.st || packet_count !== want.pkts ||
                        syn_count !== want.syns || synack_count !== want.synacks)
                        log_mismatch($sformatf(
                            "result %0d: expected %0d %0d/%0d/%0d, got %0d %0d/%0d/%0d",
                            results_seen, want.st, want.pkts, want.syns, want.synacks,
                            status, packet_count, syn_count, synack_count));
                end
            end
            if (in_valid && in_ready)
            begin
                bytes_taken++;
                in_taken = 1'b1;
                if (parse_byte(data_byte, got))
                    tally_q.push_back(got);
            end
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        logic [15:0] port;
        int unsigned phase_bytes;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // global header: magic little-endian, link type zero
        for (int i = 0; i < 24; i++)
            pending_bytes.push_back(i < 4 ? 8'(pcap_syn_pkg::PCAP_MAGIC >> (8 * i))
                                          : (i >= 20 ? 8'h00 : 8'($urandom)));

        // directed records under the reset port
        queue_record(32'd0, 8'h45, 16'd0, 16'd0, 8'h00);
        queue_record(32'd38, 8'h45, 16'd1025, pcap_syn_pkg::SERVER_PORT_RESET,
                     pcap_syn_pkg::FLAGS_SYN);
        queue_record(32'd38, 8'h45, pcap_syn_pkg::SERVER_PORT_RESET, 16'd1025,
                     pcap_syn_pkg::FLAGS_SYNACK);
        queue_record(32'd78, 8'h4F, 16'd40000, pcap_syn_pkg::SERVER_PORT_RESET,
                     pcap_syn_pkg::FLAGS_SYN);
        queue_record(32'd77, 8'h4F, 16'd40000, pcap_syn_pkg::SERVER_PORT_RESET,
                     pcap_syn_pkg::FLAGS_SYN);
        queue_record(32'd38, 8'h40, pcap_syn_pkg::SERVER_PORT_RESET, 16'd7,
                     pcap_syn_pkg::FLAGS_SYNACK);
        queue_record(32'd40, 8'hF4, 16'd5, pcap_syn_pkg::SERVER_PORT_RESET,
                     pcap_syn_pkg::FLAGS_SYN);
        queue_record(32'd37, 8'h45, 16'd5, pcap_syn_pkg::SERVER_PORT_RESET,
                     pcap_syn_pkg::FLAGS_SYN);
        queue_record(32'd1, 8'h45, 16'd5, pcap_syn_pkg::SERVER_PORT_RESET,
                     pcap_syn_pkg::FLAGS_SYN);
        queue_record(32'd38, 8'h45, 16'd5, pcap_syn_pkg::SERVER_PORT_RESET, 8'h03);
        queue_record(32'd38, 8'h45, pcap_syn_pkg::SERVER_PORT_RESET, 16'd5,
                     pcap_syn_pkg::FLAGS_SYN);
        queue_record(32'd38, 8'h45, 16'd5, pcap_syn_pkg::SERVER_PORT_RESET + 16'd1,
                     pcap_syn_pkg::FLAGS_SYN);
        queue_record(32'd38, 8'h45, pcap_syn_pkg::SERVER_PORT_RESET,
                     pcap_syn_pkg::SERVER_PORT_RESET, pcap_syn_pkg::FLAGS_SYN);
        queue_record(32'd38, 8'h45, pcap_syn_pkg::SERVER_PORT_RESET,
                     pcap_syn_pkg::SERVER_PORT_RESET, pcap_syn_pkg::FLAGS_SYNACK);
        queue_record(32'd300, 8'h45, pcap_syn_pkg::SERVER_PORT_RESET,
                     pcap_syn_pkg::SERVER_PORT_RESET, pcap_syn_pkg::FLAGS_SYN);
        settle();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       port = 16'h0000;
                1:       port = 16'hFFFF;
                2:       port = 16'($urandom);
                default: port = pcap_syn_pkg::SERVER_PORT_RESET;
            endcase
            write_server_port(port);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
                phase_bytes += queue_random_record();
            settle();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
hdl/pcap_syn_pkg.sv
hdl/pcap_tcp_syn_counter.sv
dv/pcap_tcp_syn_counter_test.sv
